// ----- hw/rtl/rrtp_pkg.sv -----
// Shared constants, codes and controller/datapath structs for the round-robin task picker.
package rrtp_pkg;

  localparam int DEF_NUM_SLOTS = 64;
  localparam int SLOT_IDX_W    = 6;
  localparam int OUTCOME_W     = 2;
  localparam int FLAG_MAX      = 64;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_YIELD = 1'b1;

  localparam logic [OUTCOME_W-1:0] OUT_WRITTEN = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_PICKED  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_IDLE    = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_NONE    = 2'd3;

  typedef struct packed {
    logic clear;
    logic start;
    logic write_flag;
    logic step;
    logic emit_write;
    logic emit_pick;
    logic emit_fallback;
  } rrtp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hit;
    logic last_step;
  } rrtp_status_t;

endpackage

// ----- hw/rtl/rrtp_if.sv -----
// Valid/ready channel interfaces for the task picker's input and result words.
interface rrtp_in_if import rrtp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic                  runnable;

  modport source(output valid, output cmd, output slot_index, output runnable, input ready);
  modport sink(input valid, input cmd, input slot_index, input runnable, output ready);
endinterface

interface rrtp_out_if import rrtp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUTCOME_W-1:0]  outcome;
  logic [SLOT_IDX_W-1:0] picked_slot;

  modport source(output valid, output outcome, output picked_slot, input ready);
  modport sink(input valid, input outcome, input picked_slot, output ready);
endinterface

// ----- hw/rtl/rrtp_ctrl.sv -----
// Controller state machine: handshakes and sequencing of the yield scan.
module rrtp_ctrl import rrtp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_cmd,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  rrtp_status_t status,
  output rrtp_cmd_t    ctl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ctl.clear = 1'b1;
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ctl.start = 1'b1;
          if (in_cmd == CMD_WRITE) begin
            ctl.write_flag = 1'b1;
            ctl.emit_write = 1'b1;
            out_valid_nxt  = 1'b1;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status.hit) begin
          ctl.emit_pick = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (status.last_step) begin
          ctl.emit_fallback = 1'b1;
          out_valid_nxt     = 1'b1;
          state_nxt         = ST_IDLE;
        end else begin
          ctl.step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/rrtp_dp.sv -----
// Datapath: runnable flags, last pick, scan pointer and result word register.
module rrtp_dp import rrtp_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rrtp_cmd_t             ctl,
  output rrtp_status_t          status,
  input  logic [SLOT_IDX_W-1:0] in_slot_index,
  input  logic                  in_runnable,
  output logic [OUTCOME_W-1:0]  out_outcome,
  output logic [SLOT_IDX_W-1:0] out_picked_slot
);

  localparam int FLAG_DEPTH = (NUM_SLOTS < FLAG_MAX) ? NUM_SLOTS : FLAG_MAX;
  localparam int FLAG_W     = $clog2(FLAG_DEPTH);
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(NUM_SLOTS - 1);

  logic                  flags_mem [FLAG_DEPTH];
  logic                  idle_flag_r;
  logic                  rd_flag_r;
  logic [FLAG_W-1:0]     clr_r;
  logic [SLOT_W-1:0]     last_pick_r;
  logic [SLOT_W-1:0]     scan_r, scan_nxt;
  logic [SLOT_W-1:0]     step_r;
  logic [SLOT_W-1:0]     first_slot;
  logic [SLOT_W-1:0]     next_slot;
  logic [OUTCOME_W-1:0]  outcome_r;
  logic [SLOT_IDX_W-1:0] picked_r;
  logic                  rd_in_range;
  logic                  wr_in_range;

  assign first_slot  = (last_pick_r == TOP_SLOT) ? SLOT_W'(1) : last_pick_r + SLOT_W'(1);
  assign next_slot   = (scan_r == TOP_SLOT) ? SLOT_W'(1) : scan_r + SLOT_W'(1);
  assign scan_nxt    = ctl.start ? first_slot : next_slot;
  assign rd_in_range = 32'(scan_nxt) < FLAG_DEPTH;
  assign wr_in_range = 32'(in_slot_index) < NUM_SLOTS;

  assign status.clear_done = (clr_r == FLAG_W'(FLAG_DEPTH - 1));
  assign status.hit        = rd_flag_r;
  assign status.last_step  = (step_r == TOP_SLOT);

  assign out_outcome     = outcome_r;
  assign out_picked_slot = picked_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_flag_r <= 1'b0;
      last_pick_r <= '0;
      clr_r       <= '0;
    end else begin
      if (ctl.clear) begin
        clr_r <= clr_r + FLAG_W'(1);
      end
      if (ctl.write_flag && in_slot_index == '0) begin
        idle_flag_r <= in_runnable;
      end
      if (ctl.emit_pick) begin
        last_pick_r <= scan_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      flags_mem[clr_r] <= 1'b0;
    end else if (ctl.write_flag && wr_in_range) begin
      flags_mem[in_slot_index[FLAG_W-1:0]] <= in_runnable;
    end
    if (ctl.start || ctl.step) begin
      rd_flag_r <= rd_in_range ? flags_mem[scan_nxt[FLAG_W-1:0]] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start || ctl.step) begin
      scan_r <= scan_nxt;
      step_r <= ctl.start ? SLOT_W'(1) : step_r + SLOT_W'(1);
    end
    if (ctl.emit_write) begin
      outcome_r <= OUT_WRITTEN;
      picked_r  <= '0;
    end else if (ctl.emit_pick) begin
      outcome_r <= OUT_PICKED;
      picked_r  <= SLOT_IDX_W'(scan_r);
    end else if (ctl.emit_fallback) begin
      outcome_r <= idle_flag_r ? OUT_IDLE : OUT_NONE;
      picked_r  <= '0;
    end
  end

endmodule

// ----- hw/rtl/round_robin_task_picker_core.sv -----
// Top level of the round-robin task picker: controller, datapath and channel wiring.
//
// Input words carry cmd, slot_index and runnable. A write word (cmd 0) sets the
// runnable flag of slot_index; slots at or above NUM_SLOTS are left alone. A
// yield word (cmd 1) walks slots 1 to NUM_SLOTS-1 in circular order from just
// after the last pick and returns the first runnable one, else slot 0 if the
// idle task is runnable, else outcome "nothing runnable".
// Each input word yields exactly one result word (outcome, picked_slot).
// A write's result word is registered on acceptance. A yield checks one flag per
// cycle via the scan pointer and answers at the first runnable slot or walk end.
// One word is in work at a time; in_ready rises again once the result register
// is empty or being drained, so writes run one per cycle while out_ready is high.
// Reset (rst_n low, synchronous) clears the last pick and the result valid, then
// a clearing pass zeroes the flag memory one entry per cycle; in_ready stays low
// until it ends. While the receiver stalls, the result word holds and no new
// input word is taken.
module round_robin_task_picker_core import rrtp_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic  clk,
  input  logic  rst_n,
  rrtp_in_if.sink    in_chan,
  rrtp_out_if.source out_chan
);

  rrtp_cmd_t    ctl;
  rrtp_status_t status;

  rrtp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_cmd    (in_chan.cmd),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .ctl       (ctl)
  );

  rrtp_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .status          (status),
    .in_slot_index   (in_chan.slot_index),
    .in_runnable     (in_chan.runnable),
    .out_outcome     (out_chan.outcome),
    .out_picked_slot (out_chan.picked_slot)
  );

endmodule

// ----- hw/rtl/rrtp_checker.sv -----
// Port-level assertions for the task picker and their bind to the top level.
module rrtp_checker import rrtp_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [OUTCOME_W-1:0]  outcome,
  input logic [SLOT_IDX_W-1:0] picked_slot
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(picked_slot))
    else $error("result word changed while stalled");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result word pending");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (outcome == OUT_WRITTEN || outcome == OUT_NONE || outcome == OUT_IDLE)
      |-> picked_slot == '0)
    else $error("nonzero slot with write, idle or empty outcome");

  a_pick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && outcome == OUT_PICKED |-> picked_slot != '0)
    else $error("regular pick returned the idle slot");

endmodule

bind round_robin_task_picker_core rrtp_checker u_rrtp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .outcome     (out_chan.outcome),
  .picked_slot (out_chan.picked_slot)
);
